// ===== rtl/core/tar_pkg.sv =====
`default_nettype none

package tar_pkg;

	localparam int TEXT_COLS = 40;
	localparam int TEXT_ROWS = 24;

	localparam int COL_W     = 6;
	localparam int CROW_W    = 5;
	localparam int PROW_W    = 3;
	localparam int CELL_W    = 10;
	localparam int VADDR_W   = 11;
	localparam int BYTE_W    = 8;
	localparam int BLINK_W   = 20;
	localparam int TICK_W    = 4;
	localparam int IDX_W     = 3;
	localparam int SCAN_W    = 8;

	localparam logic [BLINK_W-1:0] BLINK_RELOAD_RST = 20'd786432;

	localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(TEXT_COLS - 1);
	localparam logic [CROW_W-1:0] LAST_CROW    = CROW_W'(TEXT_ROWS - 1);
	localparam logic [PROW_W-1:0] LAST_PROW    = '1;
	localparam logic [CELL_W-1:0] ROW_STRIDE   = CELL_W'(TEXT_COLS % (1 << CELL_W));

	typedef enum logic [1:0] {
		OP_VRAM_WR = 2'd0,
		OP_FONT_WR = 2'd1,
		OP_TICK    = 2'd2,
		OP_RENDER  = 2'd3
	} op_t;

	// Blink step table for short reload values: index {ticks left, reload[3:0]},
	// entry {odd number of toggles, count after}, starting from count == reload.
	typedef logic [255:0][4:0] tick_tab_t;

	function automatic tick_tab_t build_tick_tab();
		tick_tab_t tab;
		int        cnt;
		logic      tog;
		tab = '0;
		for (int r = 0; r < 16; r++) begin
			for (int k = 0; k < 16; k++) begin
				cnt = k;
				tog = 1'b0;
				for (int i = 0; i < r; i++) begin
					if (cnt == 0) begin
						cnt = k;
						tog = ~tog;
					end else begin
						cnt = cnt - 1;
					end
				end
				tab[8'(r * 16 + k)] = {tog, 4'(cnt)};
			end
		end
		return tab;
	endfunction

	localparam tick_tab_t TICK_TAB = build_tick_tab();

endpackage

`default_nettype wire

// ===== rtl/core/text_mode_attribute_raster.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// cfg       in         cfg_we                 cfg_data (blink reload)
// in        in         in_valid / in_stall    op, address, data, tick_count
// out       out        out_valid / out_stall  pixel_bits, fg_index, bg_index,
//                                             cell_column, scan_line, frame_end
//
// One item per cycle while in_stall is low. A render transfer reads the
// char/color RAM at accept into stage 1, then the font RAM into the output
// register on out_load. RAM and tick items finish at the accept edge.
// Reset clears raster position, blink state and valid flags and loads the
// blink reload default; the RAMs have no clearing pass and must be written
// before they are read. in_stall rises only while a render sits in stage 1
// and the output register is full and stalled.

module text_mode_attribute_raster (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          cfg_we,
	input  wire logic [tar_pkg::BLINK_W-1:0]   cfg_data,

	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    op,
	input  wire logic [tar_pkg::VADDR_W-1:0]   address,
	input  wire logic [tar_pkg::BYTE_W-1:0]    data,
	input  wire logic [tar_pkg::TICK_W-1:0]    tick_count,

	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [tar_pkg::BYTE_W-1:0]         pixel_bits,
	output logic [tar_pkg::IDX_W-1:0]          fg_index,
	output logic [tar_pkg::IDX_W-1:0]          bg_index,
	output logic [tar_pkg::COL_W-1:0]          cell_column,
	output logic [tar_pkg::SCAN_W-1:0]         scan_line,
	output logic                               frame_end
);
	import tar_pkg::*;

	// memories
	logic [BYTE_W-1:0] char_mem  [1 << CELL_W];
	logic [BYTE_W-1:0] color_mem [1 << CELL_W];
	logic [BYTE_W-1:0] font_mem  [1 << VADDR_W];

	// config / blink
	logic [BLINK_W-1:0] reload_q;
	logic [BLINK_W-1:0] blink_cnt_q;
	logic               blink_on_q;
	logic [BLINK_W-1:0] blink_cnt_nxt;
	logic               blink_tog;

	// raster position
	logic [COL_W-1:0]  col_q;
	logic [PROW_W-1:0] prow_q;
	logic [CROW_W-1:0] crow_q;
	logic [CELL_W-1:0] row_base_q;
	logic [CELL_W-1:0] cell_idx;
	logic              last_cell;

	// stage 1: char/attr read data plus side info
	logic              s1_valid_q;
	logic [BYTE_W-1:0] chr_s1;
	logic [BYTE_W-1:0] attr_s1;
	logic              blink_s1;
	logic [PROW_W-1:0] prow_s1;
	logic [COL_W-1:0]  col_s1;
	logic [SCAN_W-1:0] scan_s1;
	logic              last_s1;

	// stage 2: output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] pix_s2;
	logic [IDX_W-1:0]  fg_s2;
	logic [IDX_W-1:0]  bg_s2;
	logic [COL_W-1:0]  col_s2;
	logic [SCAN_W-1:0] scan_s2;
	logic              last_s2;

	logic accept;
	logic render;
	logic out_load;
	logic swap;

	// handshake
	assign out_load = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !out_load;
	assign accept   = in_valid && !in_stall;
	assign render   = accept && (op == OP_RENDER);

	// raster addressing: row_base tracks charrow*TEXT_COLS mod 1024
	assign cell_idx  = row_base_q + CELL_W'(col_q);
	assign last_cell = (col_q == LAST_COL) && (prow_q == LAST_PROW) && (crow_q == LAST_CROW);

	// blink: closed form over up to 15 ticks
	always_comb begin
		logic [TICK_W-1:0] rem;
		logic [4:0]        ent;
		rem           = '0;
		ent           = '0;
		blink_cnt_nxt = blink_cnt_q;
		blink_tog     = 1'b0;
		if (BLINK_W'(tick_count) <= blink_cnt_q) begin
			blink_cnt_nxt = blink_cnt_q - BLINK_W'(tick_count);
		end else begin
			// ticks left after the first reload
			rem = tick_count - blink_cnt_q[TICK_W-1:0] - TICK_W'(1);
			if (reload_q[BLINK_W-1:TICK_W] == '0) begin
				ent           = TICK_TAB[{rem, reload_q[TICK_W-1:0]}];
				blink_cnt_nxt = BLINK_W'(ent[3:0]);
				blink_tog     = ~ent[4];
			end else begin
				blink_cnt_nxt = reload_q - BLINK_W'(rem);
				blink_tog     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q    <= BLINK_RELOAD_RST;
			blink_cnt_q <= '0;
			blink_on_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				reload_q <= cfg_data;
			end
			if (accept && (op == OP_TICK)) begin
				blink_cnt_q <= blink_cnt_nxt;
				blink_on_q  <= blink_on_q ^ blink_tog;
			end
		end
	end

	// raster walk: column, pixel row, character row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			prow_q     <= '0;
			crow_q     <= '0;
			row_base_q <= '0;
		end else if (render) begin
			if (col_q == LAST_COL) begin
				col_q <= '0;
				if (prow_q == LAST_PROW) begin
					prow_q <= '0;
					if (crow_q == LAST_CROW) begin
						crow_q     <= '0;
						row_base_q <= '0;
					end else begin
						crow_q     <= crow_q + CROW_W'(1);
						row_base_q <= row_base_q + ROW_STRIDE;
					end
				end else begin
					prow_q <= prow_q + PROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// video RAMs: write at accept, render reads the cell
	always_ff @(posedge clk) begin
		if (accept && (op == OP_VRAM_WR) && address[CELL_W]) begin
			char_mem[address[CELL_W-1:0]] <= data;
		end
		if (render) begin
			chr_s1 <= char_mem[cell_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (op == OP_VRAM_WR) && !address[CELL_W]) begin
			color_mem[address[CELL_W-1:0]] <= data;
		end
		if (render) begin
			attr_s1 <= color_mem[cell_idx];
		end
	end

	// font RAM: read is old-data, so a write accepted on the same edge
	// (a later item) does not leak into this render
	always_ff @(posedge clk) begin
		if (accept && (op == OP_FONT_WR)) begin
			font_mem[address] <= data;
		end
		if (out_load) begin
			pix_s2 <= font_mem[{chr_s1, prow_s1}];
		end
	end

	// stage 1 side info
	always_ff @(posedge clk) begin
		if (render) begin
			blink_s1 <= blink_on_q;
			prow_s1  <= prow_q;
			col_s1   <= col_q;
			scan_s1  <= {crow_q, prow_q};
			last_s1  <= last_cell;
		end
	end

	assign swap = attr_s1[7] && blink_s1;

	always_ff @(posedge clk) begin
		if (out_load) begin
			fg_s2   <= swap ? attr_s1[2:0] : attr_s1[6:4];
			bg_s2   <= swap ? attr_s1[6:4] : attr_s1[2:0];
			col_s2  <= col_s1;
			scan_s2 <= scan_s1;
			last_s2 <= last_s1;
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (render) begin
				s1_valid_q <= 1'b1;
			end else if (out_load) begin
				s1_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_bits  = pix_s2;
	assign fg_index    = fg_s2;
	assign bg_index    = bg_s2;
	assign cell_column = col_s2;
	assign scan_line   = scan_s2;
	assign frame_end   = last_s2;

endmodule

`default_nettype wire
